### hw/rtl/smp_sld_pkg.sv
// Shared types, constants and helper functions for the SMP serial line deframer.
// No dependencies; every other file of the block imports this package.
package smp_sld_pkg;

   localparam logic [7:0] LINE_FEED = 8'h0a;
   localparam logic [7:0] PAD_CHAR  = 8'h3d;   // '='
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [15:0] START_HDR_RESET = 16'h0609;
   localparam logic [15:0] CONT_HDR_RESET  = 16'h0414;

   // register indexes, one word apart
   localparam logic CSR_START_HDR = 1'b0;
   localparam logic CSR_CONT_HDR  = 1'b1;
   localparam int CSR_AW = 3;

   // end item status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_CRC   = 2'd1;
   localparam logic [1:0] ST_B64   = 2'd2;
   localparam logic [1:0] ST_ABORT = 2'd3;

   // output queue
   localparam int OQ_DEPTH = 4;
   localparam int OQ_AW    = 2;

   typedef struct packed {
      logic [15:0] start_hdr;
      logic [15:0] cont_hdr;
   } smp_sld_hdr_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       end_of_packet;
      logic [1:0] status;
   } smp_sld_item_type;

   // results of one processed byte: optional payload item, then optional end item
   typedef struct packed {
      logic       push;
      logic       pay_v;
      logic [7:0] pay_byte;
      logic       end_v;
      logic [1:0] end_status;
   } smp_sld_push_type;

   // {ok, value}
   function automatic logic [6:0] b64_decode(input logic [7:0] c);
      logic [6:0] r;
      r = 7'd0;
      if (c >= 8'h41 && c <= 8'h5a)      r = {1'b1, 6'(c - 8'h41)};
      else if (c >= 8'h61 && c <= 8'h7a) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      else if (c == 8'h2b)               r = {1'b1, 6'd62};
      else if (c == 8'h2f)               r = {1'b1, 6'd63};
      return r;
   endfunction

   // CRC-16, poly 0x1021, MSB first, one byte
   function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
         else c = {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

### hw/rtl/smp_sld_csr.sv
// Configuration registers of the deframer: start and continuation headers.
// APB-style write/read port; uses smp_sld_pkg.
module smp_sld_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [smp_sld_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready,
   output smp_sld_pkg::smp_sld_hdr_type   hdr
);
   import smp_sld_pkg::*;

   logic [15:0] start_hdr_ff, start_hdr_in;
   logic [15:0] cont_hdr_ff, cont_hdr_in;
   logic        wr_en;
   logic        sel;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign sel = csr_paddr[2];

   always_comb begin
      start_hdr_in = start_hdr_ff;
      cont_hdr_in  = cont_hdr_ff;
      if (wr_en) begin
         case (sel)
            CSR_START_HDR: start_hdr_in = csr_pwdata[15:0];
            CSR_CONT_HDR:  cont_hdr_in  = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_hdr_ff <= START_HDR_RESET;
         cont_hdr_ff  <= CONT_HDR_RESET;
      end else begin
         start_hdr_ff <= start_hdr_in;
         cont_hdr_ff  <= cont_hdr_in;
      end
   end

   always_comb begin
      case (sel)
         CSR_START_HDR: csr_prdata = {16'h0000, start_hdr_ff};
         CSR_CONT_HDR:  csr_prdata = {16'h0000, cont_hdr_ff};
         default:       csr_prdata = 32'h0000_0000;
      endcase
   end

   assign hdr.start_hdr = start_hdr_ff;
   assign hdr.cont_hdr  = cont_hdr_ff;

endmodule

### hw/rtl/smp_sld_core.sv
// Input register plus per-byte deframing logic: header hunt, base64 decode,
// length capture, CRC-16 and two-byte holdback. Uses smp_sld_pkg.
module smp_sld_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [7:0]                     req_rx_byte,
   output logic                           req_stall,
   input  smp_sld_pkg::smp_sld_hdr_type   hdr,
   input  logic                           space,
   output smp_sld_pkg::smp_sld_push_type  push
);
   import smp_sld_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_START,
      PH_CONT
   } phase_type;

   typedef enum logic [1:0] {
      PAD_NONE,
      PAD_ONE,
      PAD_CLOSED
   } pad_type;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        fire;
   logic        accept;

   phase_type   phase_ff, phase_in;
   pad_type     pad_ff, pad_in;
   logic [7:0]  prev_ff, prev_in;
   logic        open_ff, open_in;
   logic [1:0]  grp_ff, grp_in;
   logic [11:0] acc_ff, acc_in;
   logic [15:0] dlen_ff, dlen_in;
   logic [1:0]  lbt_ff, lbt_in;
   logic [15:0] brx_ff, brx_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  hb0_ff, hb0_in;
   logic [7:0]  hb1_ff, hb1_in;
   logic [1:0]  hbc_ff, hbc_in;

   logic [7:0]  c;
   logic [6:0]  b64;
   logic [5:0]  v;
   logic        take;
   logic [7:0]  tb;
   logic        close;
   logic [1:0]  close_st;
   logic        start;
   logic        cont;
   logic [15:0] new_len;

   assign fire      = in_valid_ff && space;
   assign req_stall = in_valid_ff && !space;
   assign accept    = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !fire);

   assign c   = in_byte_ff;
   assign b64 = b64_decode(c);
   assign v   = b64[5:0];

   always_comb begin
      phase_in = phase_ff;
      pad_in   = pad_ff;
      prev_in  = c;
      open_in  = open_ff;
      grp_in   = grp_ff;
      acc_in   = acc_ff;
      dlen_in  = dlen_ff;
      lbt_in   = lbt_ff;
      brx_in   = brx_ff;
      crc_in   = crc_ff;
      hb0_in   = hb0_ff;
      hb1_in   = hb1_ff;
      hbc_in   = hbc_ff;
      take     = 1'b0;
      tb       = 8'h00;
      close    = 1'b0;
      close_st = ST_OK;
      start    = 1'b0;
      cont     = 1'b0;
      new_len  = {dlen_ff[7:0], 8'h00};
      push.push       = fire;
      push.pay_v      = 1'b0;
      push.pay_byte   = hb0_ff;
      push.end_v      = 1'b0;
      push.end_status = ST_OK;

      if (phase_ff != PH_IDLE) begin
         if (c == LINE_FEED) begin
            if (grp_ff != 2'd0 || (phase_ff == PH_START && lbt_ff < 2'd2)) begin
               close    = 1'b1;
               close_st = ST_B64;
            end
            phase_in = PH_IDLE;
         end else if (pad_ff == PAD_CLOSED) begin
            close    = 1'b1;
            close_st = ST_B64;
         end else if (c == PAD_CHAR) begin
            if (grp_ff == 2'd2 && pad_ff == PAD_NONE) begin
               pad_in = PAD_ONE;
               grp_in = 2'd3;
            end else if (grp_ff == 2'd3) begin
               pad_in = PAD_CLOSED;
               grp_in = 2'd0;
            end else begin
               close    = 1'b1;
               close_st = ST_B64;
            end
         end else if (!b64[6] || pad_ff != PAD_NONE) begin
            close    = 1'b1;
            close_st = ST_B64;
         end else begin
            // acc keeps the last two sextets; each step after the first of a group yields the next byte
            case (grp_ff)
               2'd0: begin
                  acc_in = {6'd0, v};
                  grp_in = 2'd1;
               end
               2'd1: begin
                  acc_in = {acc_ff[5:0], v};
                  grp_in = 2'd2;
                  take   = 1'b1;
                  tb     = {acc_ff[5:0], v[5:4]};
               end
               2'd2: begin
                  acc_in = {acc_ff[5:0], v};
                  grp_in = 2'd3;
                  take   = 1'b1;
                  tb     = {acc_ff[3:0], v[5:2]};
               end
               default: begin
                  acc_in = 12'd0;
                  grp_in = 2'd0;
                  take   = 1'b1;
                  tb     = {acc_ff[1:0], v};
               end
            endcase
         end
      end else begin
         if ({prev_ff, c} == hdr.start_hdr) begin
            close    = 1'b1;
            close_st = ST_ABORT;
            start    = 1'b1;
         end else if ({prev_ff, c} == hdr.cont_hdr && open_ff) begin
            cont = 1'b1;
         end
      end

      if (take) begin
         if (lbt_ff < 2'd2) begin
            // first two decoded bytes: big-endian length
            new_len = {dlen_ff[7:0], tb};
            dlen_in = new_len;
            lbt_in  = lbt_ff + 2'd1;
            if (lbt_ff == 2'd1 && new_len < 16'd2) begin
               close    = 1'b1;
               close_st = ST_CRC;
            end
         end else begin
            crc_in = crc_next(crc_ff, tb);
            if (hbc_ff >= 2'd2) begin
               push.pay_v    = fire;
               push.pay_byte = hb0_ff;
               hb0_in = hb1_ff;
               hb1_in = tb;
            end else begin
               if (hbc_ff[0]) hb1_in = tb;
               else hb0_in = tb;
               hbc_in = hbc_ff + 2'd1;
            end
            brx_in = brx_ff + 16'd1;
            if (brx_in == dlen_ff) begin
               close    = 1'b1;
               close_st = (crc_in == 16'd0) ? ST_OK : ST_CRC;
            end
         end
      end

      if (close) begin
         if (open_ff) begin
            push.end_v      = fire;
            push.end_status = close_st;
         end
         open_in  = 1'b0;
         hbc_in   = 2'd0;
         phase_in = PH_IDLE;
      end

      if (start) begin
         open_in  = 1'b1;
         dlen_in  = 16'd0;
         lbt_in   = 2'd0;
         brx_in   = 16'd0;
         crc_in   = 16'd0;
         hb0_in   = 8'h00;
         hb1_in   = 8'h00;
         hbc_in   = 2'd0;
         phase_in = PH_START;
         grp_in   = 2'd0;
         acc_in   = 12'd0;
         pad_in   = PAD_NONE;
      end

      if (cont) begin
         phase_in = PH_CONT;
         grp_in   = 2'd0;
         acc_in   = 12'd0;
         pad_in   = PAD_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_IDLE;
         pad_ff      <= PAD_NONE;
         prev_ff     <= 8'h00;
         open_ff     <= 1'b0;
         grp_ff      <= 2'd0;
         acc_ff      <= 12'd0;
         dlen_ff     <= 16'd0;
         lbt_ff      <= 2'd0;
         brx_ff      <= 16'd0;
         crc_ff      <= 16'd0;
         hb0_ff      <= 8'h00;
         hb1_ff      <= 8'h00;
         hbc_ff      <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            phase_ff <= phase_in;
            pad_ff   <= pad_in;
            prev_ff  <= prev_in;
            open_ff  <= open_in;
            grp_ff   <= grp_in;
            acc_ff   <= acc_in;
            dlen_ff  <= dlen_in;
            lbt_ff   <= lbt_in;
            brx_ff   <= brx_in;
            crc_ff   <= crc_in;
            hb0_ff   <= hb0_in;
            hb1_ff   <= hb1_in;
            hbc_ff   <= hbc_in;
         end
      end
   end

endmodule

### hw/rtl/smp_sld_outq.sv
// Small result queue: takes up to two items per cycle, hands out one while rsp_stall is low.
// Uses smp_sld_pkg.
module smp_sld_outq (
   input  logic                           clock,
   input  logic                           reset,
   input  smp_sld_pkg::smp_sld_push_type  push,
   output logic                           space,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_payload_byte,
   output logic                           rsp_end_of_packet,
   output logic [1:0]                     rsp_status
);
   import smp_sld_pkg::*;

   smp_sld_item_type       entry_ff [OQ_DEPTH];
   logic [OQ_AW-1:0]       wp_ff, wp_in;
   logic [OQ_AW-1:0]       rp_ff, rp_in;
   logic [OQ_AW:0]         cnt_ff, cnt_in;
   logic [OQ_AW-1:0]       wp1;
   logic                   push0;
   logic                   push1;
   logic                   pop;
   smp_sld_item_type       pay_item;
   smp_sld_item_type       end_item;
   smp_sld_item_type       first;
   smp_sld_item_type       head;

   assign pay_item.payload_byte  = push.pay_byte;
   assign pay_item.end_of_packet = 1'b0;
   assign pay_item.status        = ST_OK;
   assign end_item.payload_byte  = 8'h00;
   assign end_item.end_of_packet = 1'b1;
   assign end_item.status        = push.end_status;

   assign first = push.pay_v ? pay_item : end_item;
   assign push0 = push.push && (push.pay_v || push.end_v);
   assign push1 = push.push && push.pay_v && push.end_v;
   assign wp1   = wp_ff + OQ_AW'(1);

   // room for two more items, the most one byte can produce
   assign space = cnt_ff <= (OQ_AW + 1)'(OQ_DEPTH - 2);

   assign rsp_valid = cnt_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = entry_ff[rp_ff];
   assign rsp_payload_byte  = head.payload_byte;
   assign rsp_end_of_packet = head.end_of_packet;
   assign rsp_status        = head.status;

   assign wp_in  = wp_ff + OQ_AW'(push0) + OQ_AW'(push1);
   assign rp_in  = rp_ff + OQ_AW'(pop);
   assign cnt_in = cnt_ff + (OQ_AW + 1)'(push0) + (OQ_AW + 1)'(push1)
                   - (OQ_AW + 1)'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < OQ_DEPTH; i++) begin
         if (push0 && wp_ff == OQ_AW'(i)) entry_ff[i] <= first;
         if (push1 && wp1 == OQ_AW'(i)) entry_ff[i] <= end_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### hw/rtl/smp_serial_line_deframer.sv
// SMP serial line deframer, top level.
// Raw serial bytes enter on the req_ channel (valid/stall), one per item.
// The block hunts for the start or continuation header, base64-decodes each
// line up to the line feed, takes the first two decoded bytes of a packet as
// its length, runs CRC-16 (poly 0x1021, init 0) over the rest and emits
// payload bytes on the rsp_ channel, holding back the two CRC bytes. When
// the declared length is reached an end item with a status code follows.
// Headers are set through the csr_ port (offset 0 start, 4 continuation).
// Throughput: one byte per cycle while the result queue has room. A byte is
// held in the input register and then decoded into a four-entry result
// queue, whose head drives rsp_. A byte can produce two results (last
// payload byte plus end item); the input stalls while the queue has room
// for fewer than two.
// Reset clears all line and packet state and restores the header defaults.
// A stall on rsp_ fills the queue, after which req_stall rises; nothing is
// lost or reordered.
// Uses smp_sld_pkg, smp_sld_csr, smp_sld_core, smp_sld_outq.
module smp_serial_line_deframer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [7:0]                     req_rx_byte,
   output logic                           req_stall,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_payload_byte,
   output logic                           rsp_end_of_packet,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [smp_sld_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import smp_sld_pkg::*;

   smp_sld_hdr_type  hdr;
   smp_sld_push_type push;
   logic             space;

   smp_sld_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .hdr         (hdr)
   );

   smp_sld_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .hdr         (hdr),
      .space       (space),
      .push        (push)
   );

   smp_sld_outq u_outq (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .space             (space),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_end_of_packet (rsp_end_of_packet),
      .rsp_status        (rsp_status)
   );

endmodule

### bench/smp_serial_line_deframer_test.sv
// Self-checking bench for smp_serial_line_deframer: framed base64 packets with
// random content, broken lines and noise, checked against a built-in predictor.
// Depends on smp_sld_pkg and the smp_serial_line_deframer RTL.
module smp_serial_line_deframer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import smp_sld_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [CSR_AW-1:0] START_HDR_ADDR = {CSR_START_HDR, 2'b00};
   localparam logic [CSR_AW-1:0] CONT_HDR_ADDR  = {CSR_CONT_HDR, 2'b00};

   typedef enum logic [1:0] {LINE_IDLE, LINE_START, LINE_CONT} line_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic rsp_end_of_packet;
   logic [1:0] rsp_status;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   smp_serial_line_deframer dut (.*);

   always #2 clock = ~clock;

   // predictor state and header copy
   logic [15:0] start_hdr_cfg = START_HDR_RESET;
   logic [15:0] cont_hdr_cfg  = CONT_HDR_RESET;
   line_kind_type line_kind = LINE_IDLE;
   logic [7:0]  last_rx = 8'h00;
   logic        pkt_open = 1'b0;
   logic [1:0]  grp_pos = 2'd0;
   logic [17:0] grp_bits = '0;
   logic [1:0]  pad_state = 2'd0;
   logic [15:0] len_field = '0;
   logic [1:0]  len_count = 2'd0;
   logic [15:0] pay_count = '0;
   logic [15:0] crc_acc = '0;
   logic [7:0]  hold_bytes [2] = '{8'h00, 8'h00};
   logic [1:0]  hold_n = 2'd0;

   smp_sld_item_type expected_items[$];
   logic [7:0] pending_bytes[$];
   logic [7:0] packet_bytes[$];
   logic [7:0] line_text[$];

   int bytes_queued = 0;
   int bytes_taken = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_gap = 0;
   bit send_calm = 1'b0;
   int hold_left = 0;
   bit hold_calm = 1'b0;
   smp_sld_item_type want;

   function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] d);
      logic [15:0] r;
      r = crc ^ {d, 8'h00};
      repeat (8) r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      return r;
   endfunction

   function automatic int sextet_of(logic [7:0] c);
      int v;
      v = -1;
      if (c >= 8'h41 && c <= 8'h5a) v = int'(c) - 'h41;
      else if (c >= 8'h61 && c <= 8'h7a) v = int'(c) - 'h61 + 26;
      else if (c >= 8'h30 && c <= 8'h39) v = int'(c) - 'h30 + 52;
      else if (c == 8'h2b) v = 62;
      else if (c == 8'h2f) v = 63;
      return v;
   endfunction

   function automatic logic [7:0] sextet_char(logic [5:0] v);
      if (v < 26) return 8'h41 + 8'(v);
      if (v < 52) return 8'h61 + 8'(v - 26);
      if (v < 62) return 8'h30 + 8'(v - 52);
      return (v == 62) ? 8'h2b : 8'h2f;
   endfunction

   function automatic void expect_item(logic [7:0] d, logic eop, logic [1:0] st);
      smp_sld_item_type it;
      it.payload_byte = d;
      it.end_of_packet = eop;
      it.status = st;
      expected_items.push_back(it);
   endfunction

   function automatic void end_packet(logic [1:0] st);
      if (pkt_open) expect_item(8'h00, 1'b1, st);
      pkt_open = 1'b0;
      hold_n = 2'd0;
      line_kind = LINE_IDLE;
   endfunction

   function automatic void take_decoded(logic [7:0] d);
      if (len_count < 2) begin
         len_field = {len_field[7:0], d};
         len_count++;
         if (len_count == 2 && len_field < 2) end_packet(ST_CRC);
         return;
      end
      crc_acc = crc16_step(crc_acc, d);
      // two-byte delay line keeps the CRC trailer off the output
      if (hold_n >= 2) begin
         expect_item(hold_bytes[0], 1'b0, ST_OK);
         hold_bytes[0] = hold_bytes[1];
         hold_bytes[1] = d;
      end else begin
         hold_bytes[hold_n[0]] = d;
         hold_n++;
      end
      pay_count++;
      if (pay_count == len_field) end_packet(crc_acc == 16'h0 ? ST_OK : ST_CRC);
   endfunction

   function automatic void line_char(logic [7:0] c);
      int v;
      if (c == LINE_FEED) begin
         if (grp_pos != 0 || (line_kind == LINE_START && len_count < 2)) end_packet(ST_B64);
         line_kind = LINE_IDLE;
         return;
      end
      if (pad_state == 2) begin
         end_packet(ST_B64);
         return;
      end
      if (c == PAD_CHAR) begin
         if (grp_pos == 2 && pad_state == 0) begin
            pad_state = 2'd1;
            grp_pos = 2'd3;
         end else if (grp_pos == 3) begin
            pad_state = 2'd2;
            grp_pos = 2'd0;
         end else begin
            end_packet(ST_B64);
         end
         return;
      end
      v = sextet_of(c);
      if (v < 0 || pad_state != 0) begin
         end_packet(ST_B64);
         return;
      end
      case (grp_pos)
         2'd0: begin
            grp_bits = 18'(v);
            grp_pos = 2'd1;
         end
         2'd1: begin
            grp_bits = {6'd0, grp_bits[5:0], 6'(v)};
            grp_pos = 2'd2;
            take_decoded(grp_bits[11:4]);
         end
         2'd2: begin
            grp_bits = {grp_bits[11:0], 6'(v)};
            grp_pos = 2'd3;
            take_decoded(grp_bits[9:2]);
         end
         default: begin
            grp_pos = 2'd0;
            take_decoded({grp_bits[1:0], 6'(v)});
            grp_bits = '0;
         end
      endcase
   endfunction

   function automatic void deframe_byte(logic [7:0] c);
      logic [15:0] pair;
      pair = {last_rx, c};
      if (line_kind != LINE_IDLE) begin
         line_char(c);
      end else if (pair == start_hdr_cfg) begin
         end_packet(ST_ABORT);
         pkt_open = 1'b1;
         len_field = '0;
         len_count = 2'd0;
         pay_count = '0;
         crc_acc = '0;
         hold_bytes = '{8'h00, 8'h00};
         hold_n = 2'd0;
         line_kind = LINE_START;
         grp_pos = 2'd0;
         grp_bits = '0;
         pad_state = 2'd0;
      end else if (pair == cont_hdr_cfg && pkt_open) begin
         line_kind = LINE_CONT;
         grp_pos = 2'd0;
         grp_bits = '0;
         pad_state = 2'd0;
      end
      last_rx = c;
   endfunction

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            deframe_byte(req_rx_byte);
            bytes_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               req_valid <= 1'b1;
               req_rx_byte <= pending_bytes.pop_front();
               if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
               send_gap = send_calm ? 0 : $urandom_range(0, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_items.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected item: byte %02h end %0d status %0d",
                           rsp_payload_byte, rsp_end_of_packet, rsp_status);
            end else begin
               want = expected_items.pop_front();
               if (rsp_payload_byte !== want.payload_byte ||
                   rsp_end_of_packet !== want.end_of_packet || rsp_status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("item mismatch: expected %02h/%0d/%0d, got %02h/%0d/%0d",
                              want.payload_byte, want.end_of_packet, want.status,
                              rsp_payload_byte, rsp_end_of_packet, rsp_status);
               end
            end
            if ($urandom_range(0, 31) == 0) hold_calm = !hold_calm;
            hold_left = hold_calm ? 0 : $urandom_range(0, 3);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   task automatic feed(logic [7:0] d);
      pending_bytes.push_back(d);
      bytes_queued++;
   endtask

   task automatic feed_text(string s);
      for (int k = 0; k < s.len(); k++) feed(s[k]);
   endtask

   function automatic logic [7:0] odd_char();
      logic [7:0] r;
      case ($urandom_range(0, 4))
         0: r = PAD_CHAR;
         1: r = 8'h0d;
         2: r = 8'h23;
         3: r = 8'h41;
         default: r = 8'($urandom);
      endcase
      return r;
   endfunction

   // base64 text of the next n bytes of packet_bytes, padded
   task automatic encode_line(int n);
      logic [23:0] grp;
      int cnt;
      line_text.delete();
      while (n > 0) begin
         cnt = (n >= 3) ? 3 : n;
         grp = '0;
         for (int k = 0; k < cnt; k++) grp[23-8*k -: 8] = packet_bytes.pop_front();
         line_text.push_back(sextet_char(grp[23:18]));
         line_text.push_back(sextet_char(grp[17:12]));
         line_text.push_back(cnt > 1 ? sextet_char(grp[11:6]) : PAD_CHAR);
         line_text.push_back(cnt > 2 ? sextet_char(grp[5:0]) : PAD_CHAR);
         n -= cnt;
      end
   endtask

   task automatic queue_packet();
      int plen, flaw, chunk, pos;
      logic [15:0] crc, dlen;
      logic [7:0] d;
      bit first;
      packet_bytes.delete();
      plen = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
      flaw = $urandom_range(0, 19);
      crc = '0;
      for (int k = 0; k < plen; k++) begin
         d = 8'($urandom);
         packet_bytes.push_back(d);
         crc = crc16_step(crc, d);
      end
      packet_bytes.push_back(crc[15:8]);
      packet_bytes.push_back(crc[7:0]);
      dlen = 16'(plen + 2);
      if (flaw == 0) dlen = 16'($urandom_range(0, plen + 5));
      if (flaw == 1) begin
         pos = $urandom_range(0, plen + 1);
         packet_bytes[pos] = packet_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
      packet_bytes.push_front(dlen[7:0]);
      packet_bytes.push_front(dlen[15:8]);
      first = 1'b1;
      while (packet_bytes.size() > 0) begin
         chunk = $urandom_range(first ? 2 : 1, 9);
         if (chunk > packet_bytes.size()) chunk = packet_bytes.size();
         encode_line(chunk);
         if (flaw == 2 && $urandom_range(0, 2) == 0)
            line_text.insert($urandom_range(0, line_text.size()), odd_char());
         if (flaw == 3 && $urandom_range(0, 2) == 0) begin
            pos = $urandom_range(1, line_text.size() - 1);
            line_text = line_text[0:pos-1];
         end
         // abandoned packet: the next start header aborts it
         if (flaw == 4 && !first && $urandom_range(0, 1) == 0) break;
         if (first) begin
            feed(start_hdr_cfg[15:8]);
            feed(start_hdr_cfg[7:0]);
         end else begin
            feed(cont_hdr_cfg[15:8]);
            feed(cont_hdr_cfg[7:0]);
         end
         foreach (line_text[k]) feed(line_text[k]);
         if (flaw == 5 && $urandom_range(0, 1) == 0) feed(8'h0d);
         feed(LINE_FEED);
         first = 1'b0;
      end
   endtask

   task automatic random_traffic(int n);
      int target;
      target = bytes_queued + n;
      while (bytes_queued < target) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 5)) feed(8'($urandom));
         end else begin
            queue_packet();
         end
      end
   endtask

   task automatic drain();
      while (bytes_taken != bytes_queued) @(posedge clock);
      while (expected_items.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_AW-1:0] addr, logic [15:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic check_csr(logic [CSR_AW-1:0] addr, logic [15:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {16'h0000, value}) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("register read at %0h: expected %08h, got %08h",
                     addr, {16'h0000, value}, csr_prdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_headers(logic [15:0] start_val, logic [15:0] cont_val);
      write_csr(START_HDR_ADDR, start_val);
      write_csr(CONT_HDR_ADDR, cont_val);
      check_csr(START_HDR_ADDR, start_val);
      check_csr(CONT_HDR_ADDR, cont_val);
      start_hdr_cfg = start_val;
      cont_hdr_cfg = cont_val;
   endtask

   logic [15:0] shared_hdr;

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // line feed while idle, then a continuation header with nothing open
      feed(LINE_FEED);
      feed(8'h04);
      feed(8'h14);
      // declared length of one
      feed(8'h06);
      feed(8'h09);
      feed_text("AAE=");
      feed(LINE_FEED);
      // open packet cut off by a new start, whose line ends mid-group
      feed(8'h06);
      feed(8'h09);
      feed_text("AAMA");
      feed(LINE_FEED);
      feed(8'h06);
      feed(8'h09);
      feed_text("AAM");
      feed(LINE_FEED);
      // empty payload, good CRC
      feed(8'h06);
      feed(8'h09);
      feed_text("AAIAAA");
      feed(LINE_FEED);
      random_traffic(140);
      drain();

      set_headers(16'hffff, 16'h0000);
      random_traffic(140);
      drain();

      set_headers(16'h0000, 16'hffff);
      random_traffic(140);
      drain();

      // same value in both: start wins
      shared_hdr = 16'($urandom);
      set_headers(shared_hdr, shared_hdr);
      random_traffic(140);
      drain();

      set_headers(16'($urandom), 16'($urandom));
      random_traffic(140);
      drain();

      set_headers(START_HDR_RESET, CONT_HDR_RESET);
      random_traffic(140);
      drain();

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
